[src/ffnp_pkg.sv]
// ----------------------------------------------------------------------------
// Font file name parser package
// Shared types, character codes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ffnp_pkg;

   localparam int NAME_CAP = 32;
   localparam int KEPT_W = $clog2(NAME_CAP);
   localparam logic [KEPT_W-1:0] KEEP_CAP = KEPT_W'(NAME_CAP - 1);

   localparam int HOLD_DEPTH = 3;
   localparam int HOLD_CNT_W = 2;

   localparam logic [7:0] CH_B    = 8'h62;
   localparam logic [7:0] CH_I    = 8'h69;
   localparam logic [7:0] CH_F    = 8'h66;
   localparam logic [7:0] CH_R    = 8'h72;
   localparam logic [7:0] CH_S    = 8'h73;
   localparam logic [7:0] CH_W    = 8'h77;
   localparam logic [7:0] CH_M    = 8'h6D;
   localparam logic [7:0] CH_D    = 8'h64;
   localparam logic [7:0] CH_DOT  = 8'h2E;

   typedef enum logic [2:0] {
      PH_FAMILY = 3'd0,
      PH_SIZE   = 3'd1,
      PH_FACE   = 3'd2,
      PH_SUFFIX = 3'd3,
      PH_FAILED = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_PARSED    = 2'd0,
      STATUS_NO_SIZE   = 2'd1,
      STATUS_ZERO_SIZE = 2'd2
   } status_type;

   typedef struct packed {
      logic shadow;
      logic fixed_width;
      logic italic;
      logic bold;
   } flags_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0]  name_char;
      logic        name_char_valid;
      logic        done_res;
      logic [15:0] point_size;
      logic [15:0] rotation;
      logic        bold;
      logic        italic;
      logic        fixed_width;
      logic        shadow;
      logic [7:0]  bad_char_count;
      status_type  status;
   } rsp_type;

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic [15:0] times_ten_plus(input logic [15:0] v, input logic [3:0] d);
      logic [19:0] sum;
      sum = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'h0000, d};
      return (sum > 20'd65535) ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

`default_nettype wire

[src/font_file_name_parser.sv]
// ----------------------------------------------------------------------------
// Font file name parser
// A character item is accepted into the input register and its result is loaded into the result register.
// Throughput: one character item per cycle while results are taken; the parse state
// updates in one pass between the input register and the result register.
// Reset clears the parse state and empties both registers; the suffix holding
// registers are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module font_file_name_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_name_char,
   output logic             rsp_name_char_valid,
   output logic             rsp_done_res,
   output logic [15:0]      rsp_point_size,
   output logic [15:0]      rsp_rotation,
   output logic             rsp_bold,
   output logic             rsp_italic,
   output logic             rsp_fixed_width,
   output logic             rsp_shadow,
   output logic [7:0]       rsp_bad_char_count,
   output logic [1:0]       rsp_status
);

   logic              item_valid;
   logic              take;
   ffnp_pkg::req_type item;
   ffnp_pkg::rsp_type result;

   ffnp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .take          (take),
      .item_valid    (item_valid),
      .item          (item)
   );

   ffnp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .item   (item),
      .result (result)
   );

   ffnp_out_stage u_out_stage (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (item_valid),
      .result              (result),
      .take                (take),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_name_char       (rsp_name_char),
      .rsp_name_char_valid (rsp_name_char_valid),
      .rsp_done_res        (rsp_done_res),
      .rsp_point_size      (rsp_point_size),
      .rsp_rotation        (rsp_rotation),
      .rsp_bold            (rsp_bold),
      .rsp_italic          (rsp_italic),
      .rsp_fixed_width     (rsp_fixed_width),
      .rsp_shadow          (rsp_shadow),
      .rsp_bad_char_count  (rsp_bad_char_count),
      .rsp_status          (rsp_status)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      item_valid && !take |-> rsp_valid && !rsp_ready)
      else $error("Held item stalled while the result register could load.");

   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("Item taken by the parser produced no result.");

   a_summary_only_when_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
         rsp_status == ffnp_pkg::STATUS_PARSED && rsp_point_size == 16'd0 &&
         rsp_rotation == 16'd0 && rsp_bad_char_count == 8'd0 &&
         !rsp_bold && !rsp_italic && !rsp_fixed_width && !rsp_shadow)
      else $error("Summary fields set on an item that is not the last.");

   a_failure_summary_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_status != ffnp_pkg::STATUS_PARSED |->
         rsp_point_size == 16'd0 && rsp_rotation == 16'd0 &&
         rsp_bad_char_count == 8'd0 &&
         !rsp_bold && !rsp_italic && !rsp_fixed_width && !rsp_shadow)
      else $error("Failure status carries nonzero summary fields.");

endmodule

`default_nettype wire

[src/ffnp_in_stage.sv]
// ----------------------------------------------------------------------------
// Input register
// Captures one character item and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ffnp_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_char_code,
   input  wire logic              req_last_char,
   input  wire logic              take,
   output logic                   item_valid,
   output ffnp_pkg::req_type      item
);

   logic              valid_ff;
   logic              valid_in;
   ffnp_pkg::req_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.char_code <= req_char_code;
         item_ff.last_char <= req_last_char;
      end
   end

endmodule

`default_nettype wire

[src/ffnp_parser.sv]
// ----------------------------------------------------------------------------
// Parser core
// Running parse state and the per-character next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ffnp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire ffnp_pkg::req_type item,
   output ffnp_pkg::rsp_type      result
);

   ffnp_pkg::phase_type            phase_ff, phase_in;
   logic [ffnp_pkg::KEPT_W-1:0]    kept_ff, kept_in;
   logic [15:0]                    size_ff, size_in;
   logic [15:0]                    rot_ff, rot_in;
   logic                           inrot_ff, inrot_in;
   ffnp_pkg::flags_type            flags_ff, flags_in;
   logic [7:0]                     err_ff, err_in;
   logic [7:0]                     hold_ff [ffnp_pkg::HOLD_DEPTH];
   logic [7:0]                     hold_in [ffnp_pkg::HOLD_DEPTH];
   logic [ffnp_pkg::HOLD_CNT_W-1:0] hold_cnt_ff, hold_cnt_in;

   logic [7:0] c;
   assign c = item.char_code;

   always_comb begin
      logic       do_size;
      logic       do_face;
      logic       ok;
      logic       held_fixed;
      logic       held_bold;
      logic [1:0] held_err;
      logic       err_inc;
      logic [9:0] err_sum;

      phase_in    = phase_ff;
      kept_in     = kept_ff;
      size_in     = size_ff;
      rot_in      = rot_ff;
      inrot_in    = inrot_ff;
      flags_in    = flags_ff;
      err_in      = err_ff;
      hold_in     = hold_ff;
      hold_cnt_in = hold_cnt_ff;
      do_size     = 1'b0;
      do_face     = 1'b0;
      ok          = 1'b0;
      held_fixed  = 1'b0;
      held_bold   = 1'b0;
      held_err    = 2'd0;
      err_inc     = 1'b0;
      err_sum     = '0;

      case (phase_ff)
         ffnp_pkg::PH_FAMILY: begin
            if (ffnp_pkg::is_letter(c)) begin
               if (kept_ff < ffnp_pkg::KEEP_CAP) begin
                  kept_in = kept_ff + ffnp_pkg::KEPT_W'(1);
               end
            end else begin
               phase_in = ffnp_pkg::PH_SIZE;
               do_size  = 1'b1;
            end
         end
         ffnp_pkg::PH_SIZE: begin
            do_size = 1'b1;
         end
         ffnp_pkg::PH_FACE: begin
            do_face = 1'b1;
         end
         ffnp_pkg::PH_SUFFIX: begin
            case (hold_cnt_ff)
               2'd0: ok = (c == ffnp_pkg::CH_F);
               2'd1: ok = (hold_ff[0] == ffnp_pkg::CH_F) &&
                          ((c == ffnp_pkg::CH_W) || (c == ffnp_pkg::CH_D));
               2'd2: ok = (hold_ff[0] == ffnp_pkg::CH_F) &&
                          (((hold_ff[1] == ffnp_pkg::CH_W) && (c == ffnp_pkg::CH_M)) ||
                           ((hold_ff[1] == ffnp_pkg::CH_D) && (c == ffnp_pkg::CH_B)));
               default: ok = 1'b0;
            endcase
            if (ok && (hold_cnt_ff == 2'd2) && item.last_char) begin
               phase_in    = ffnp_pkg::PH_FACE;
               hold_cnt_in = '0;
            end else if (ok && !item.last_char) begin
               for (int i = 0; i < ffnp_pkg::HOLD_DEPTH; i++) begin
                  if (hold_cnt_ff == ffnp_pkg::HOLD_CNT_W'(i)) begin
                     hold_in[i] = c;
                  end
               end
               hold_cnt_in = hold_cnt_ff + 2'd1;
            end else begin
               // The held characters are replayed as ordinary face characters.
               phase_in    = ffnp_pkg::PH_FACE;
               hold_cnt_in = '0;
               held_fixed  = (hold_cnt_ff != 2'd0);
               held_err    = {1'b0, (hold_cnt_ff >= 2'd2)} +
                             {1'b0, (hold_cnt_ff == 2'd3) && (hold_ff[2] == ffnp_pkg::CH_M)};
               held_bold   = (hold_cnt_ff == 2'd3) && (hold_ff[2] == ffnp_pkg::CH_B);
               do_face     = 1'b1;
            end
         end
         ffnp_pkg::PH_FAILED: begin
         end
         default: begin
         end
      endcase

      if (do_size) begin
         if (ffnp_pkg::is_digit(c)) begin
            size_in = ffnp_pkg::times_ten_plus(size_ff, c[3:0]);
         end else if (size_ff == 16'd0) begin
            phase_in = ffnp_pkg::PH_FAILED;
         end else begin
            phase_in = ffnp_pkg::PH_FACE;
            do_face  = 1'b1;
         end
      end

      if (do_face) begin
         flags_in.fixed_width = flags_ff.fixed_width | held_fixed;
         flags_in.bold        = flags_ff.bold | held_bold;
         if (inrot_ff && ffnp_pkg::is_digit(c)) begin
            rot_in = ffnp_pkg::times_ten_plus(rot_ff, c[3:0]);
         end else begin
            inrot_in = 1'b0;
            case (c)
               ffnp_pkg::CH_B:   flags_in.bold        = 1'b1;
               ffnp_pkg::CH_I:   flags_in.italic      = 1'b1;
               ffnp_pkg::CH_F:   flags_in.fixed_width = 1'b1;
               ffnp_pkg::CH_S:   flags_in.shadow      = 1'b1;
               ffnp_pkg::CH_R:   inrot_in             = 1'b1;
               ffnp_pkg::CH_DOT: begin
                  phase_in    = ffnp_pkg::PH_SUFFIX;
                  hold_cnt_in = '0;
               end
               default:          err_inc              = 1'b1;
            endcase
         end
         err_sum = {2'b00, err_ff} + {8'h00, held_err} + {9'h000, err_inc};
         err_in  = (err_sum > 10'd255) ? 8'hFF : err_sum[7:0];
      end
   end

   always_comb begin
      result = '0;
      result.status = ffnp_pkg::STATUS_PARSED;
      if ((phase_ff == ffnp_pkg::PH_FAMILY) && ffnp_pkg::is_letter(c) &&
          (kept_ff < ffnp_pkg::KEEP_CAP)) begin
         result.name_char       = c;
         result.name_char_valid = 1'b1;
      end
      if (item.last_char) begin
         result.done_res = 1'b1;
         if (phase_in == ffnp_pkg::PH_FAMILY) begin
            result.status = ffnp_pkg::STATUS_NO_SIZE;
         end else if ((phase_in == ffnp_pkg::PH_FAILED) ||
                      ((phase_in == ffnp_pkg::PH_SIZE) && (size_in == 16'd0))) begin
            result.status     = ffnp_pkg::STATUS_ZERO_SIZE;
            result.point_size = size_in;
         end else begin
            result.point_size     = size_in;
            result.rotation       = rot_in;
            result.bold           = flags_in.bold;
            result.italic         = flags_in.italic;
            result.fixed_width    = flags_in.fixed_width;
            result.shadow         = flags_in.shadow;
            result.bad_char_count = err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && item.last_char)) begin
         phase_ff    <= ffnp_pkg::PH_FAMILY;
         kept_ff     <= '0;
         size_ff     <= '0;
         rot_ff      <= '0;
         inrot_ff    <= 1'b0;
         flags_ff    <= '0;
         err_ff      <= '0;
         hold_cnt_ff <= '0;
      end else if (take) begin
         phase_ff    <= phase_in;
         kept_ff     <= kept_in;
         size_ff     <= size_in;
         rot_ff      <= rot_in;
         inrot_ff    <= inrot_in;
         flags_ff    <= flags_in;
         err_ff      <= err_in;
         hold_cnt_ff <= hold_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff <= hold_in;
      end
   end

endmodule

`default_nettype wire

[src/ffnp_out_stage.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ffnp_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire ffnp_pkg::rsp_type result,
   output logic                   take,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_name_char,
   output logic                   rsp_name_char_valid,
   output logic                   rsp_done_res,
   output logic [15:0]            rsp_point_size,
   output logic [15:0]            rsp_rotation,
   output logic                   rsp_bold,
   output logic                   rsp_italic,
   output logic                   rsp_fixed_width,
   output logic                   rsp_shadow,
   output logic [7:0]             rsp_bad_char_count,
   output logic [1:0]             rsp_status
);

   logic              valid_ff;
   logic              valid_in;
   ffnp_pkg::rsp_type result_ff;

   assign take     = in_valid && (!valid_ff || rsp_ready);
   assign valid_in = take || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_name_char       = result_ff.name_char;
   assign rsp_name_char_valid = result_ff.name_char_valid;
   assign rsp_done_res        = result_ff.done_res;
   assign rsp_point_size      = result_ff.point_size;
   assign rsp_rotation        = result_ff.rotation;
   assign rsp_bold            = result_ff.bold;
   assign rsp_italic          = result_ff.italic;
   assign rsp_fixed_width     = result_ff.fixed_width;
   assign rsp_shadow          = result_ff.shadow;
   assign rsp_bad_char_count  = result_ff.bad_char_count;
   assign rsp_status          = result_ff.status;

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Font file name parser testbench
// Feeds font file names one character item at a time and checks every result
// item against a cycle-free prediction of the parse. A short list of names
// aimed at the special cases comes first, then random names, most of them
// well formed. The sender works in bursts and the receiver stalls on
// changing patterns.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_CHARS = 1950;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_AT      = 8'h40;

   typedef struct packed {
      logic       hold_off;
      logic [7:0] code;
      logic       last;
   } char_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_name_char;
   logic        rsp_name_char_valid;
   logic        rsp_done_res;
   logic [15:0] rsp_point_size;
   logic [15:0] rsp_rotation;
   logic        rsp_bold;
   logic        rsp_italic;
   logic        rsp_fixed_width;
   logic        rsp_shadow;
   logic [7:0]  rsp_bad_char_count;
   logic [1:0]  rsp_status;

   font_file_name_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_char_code       (req_char_code),
      .req_last_char       (req_last_char),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_name_char       (rsp_name_char),
      .rsp_name_char_valid (rsp_name_char_valid),
      .rsp_done_res        (rsp_done_res),
      .rsp_point_size      (rsp_point_size),
      .rsp_rotation        (rsp_rotation),
      .rsp_bold            (rsp_bold),
      .rsp_italic          (rsp_italic),
      .rsp_fixed_width     (rsp_fixed_width),
      .rsp_shadow          (rsp_shadow),
      .rsp_bad_char_count  (rsp_bad_char_count),
      .rsp_status          (rsp_status)
   );

   always #5 clock = ~clock;

   char_item_type     pending_chars [$];
   ffnp_pkg::rsp_type parse_results_due [$];
   logic [7:0]        name_buf [$];
   logic              drain_next = 1'b0;

   ffnp_pkg::phase_type exp_phase;
   logic [5:0]          exp_kept;
   logic [15:0]         exp_size;
   logic [15:0]         exp_rot;
   logic                exp_in_rot;
   ffnp_pkg::flags_type exp_flags;
   logic [7:0]          exp_errs;
   logic [7:0]          exp_hold [0:2];
   logic [1:0]          exp_hold_cnt;

   int   fail_count = 0;
   int   chars_taken = 0;
   int   results_seen = 0;
   int   names_done = 0;
   int   drains_taken = 0;
   int   status_seen [0:2] = '{0, 0, 0};
   int   idle_cycles = 0;
   logic req_fire = 1'b0;
   int   burst_left = 1;
   int   gap_left = 0;
   int   tick = 0;
   int   ready_mode = 0;

   function automatic logic char_is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic char_is_decimal(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [15:0] grow_decimal(input logic [15:0] v, input logic [7:0] c);
      int unsigned s;
      s = int'(v) * 10 + int'(c) - 48;
      return (s > 65535) ? 16'hFFFF : s[15:0];
   endfunction

   function automatic logic suffix_start_ok(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input int n);
      logic good;
      good = 1'b1;
      if (n >= 1 && b0 != ffnp_pkg::CH_F) good = 1'b0;
      if (n >= 2 && b1 != ffnp_pkg::CH_W && b1 != ffnp_pkg::CH_D) good = 1'b0;
      if (n >= 3 && !((b1 == ffnp_pkg::CH_W && b2 == ffnp_pkg::CH_M) ||
                      (b1 == ffnp_pkg::CH_D && b2 == ffnp_pkg::CH_B))) good = 1'b0;
      return good;
   endfunction

   task automatic clear_parse_state();
      exp_phase    = ffnp_pkg::PH_FAMILY;
      exp_kept     = '0;
      exp_size     = '0;
      exp_rot      = '0;
      exp_in_rot   = 1'b0;
      exp_flags    = '0;
      exp_errs     = '0;
      exp_hold     = '{8'h00, 8'h00, 8'h00};
      exp_hold_cnt = '0;
   endtask

   task automatic apply_face_char(input logic [7:0] c);
      logic consumed;
      consumed = 1'b0;
      if (exp_in_rot) begin
         if (char_is_decimal(c)) begin
            exp_rot = grow_decimal(exp_rot, c);
            consumed = 1'b1;
         end else begin
            exp_in_rot = 1'b0;
         end
      end
      if (!consumed) begin
         case (c)
            ffnp_pkg::CH_B: begin
               exp_flags.bold = 1'b1;
            end
            ffnp_pkg::CH_I: begin
               exp_flags.italic = 1'b1;
            end
            ffnp_pkg::CH_F: begin
               exp_flags.fixed_width = 1'b1;
            end
            ffnp_pkg::CH_S: begin
               exp_flags.shadow = 1'b1;
            end
            ffnp_pkg::CH_R: begin
               exp_in_rot = 1'b1;
            end
            ffnp_pkg::CH_DOT: begin
               exp_phase = ffnp_pkg::PH_SUFFIX;
               exp_hold_cnt = '0;
            end
            default: begin
               if (exp_errs != 8'hFF) exp_errs = exp_errs + 8'd1;
            end
         endcase
      end
   endtask

   // Characters held after a dot are replayed in order once the suffix
   // cannot match; the work list stands in for the nested replay.
   task automatic feed_face(input logic [7:0] c, input logic last);
      logic [8:0] work [$];
      logic [8:0] cur;
      logic [7:0] seq [0:3];
      logic       ok;
      int         n;
      int         total;
      work.push_back({last, c});
      while (work.size() > 0) begin
         cur = work.pop_front();
         if (exp_phase != ffnp_pkg::PH_SUFFIX) begin
            apply_face_char(cur[7:0]);
         end else begin
            n = int'(exp_hold_cnt);
            for (int k = 0; k < n; k++) seq[k] = exp_hold[k];
            seq[n] = cur[7:0];
            total = n + 1;
            ok = (total <= 3) && suffix_start_ok(seq[0], seq[1], seq[2], total);
            if (ok && total == 3 && cur[8]) begin
               exp_phase = ffnp_pkg::PH_FACE;
               exp_hold_cnt = '0;
            end else if (ok && !cur[8]) begin
               exp_hold[n] = cur[7:0];
               exp_hold_cnt = 2'(total);
            end else begin
               exp_phase = ffnp_pkg::PH_FACE;
               exp_hold_cnt = '0;
               for (int k = total - 1; k >= 0; k--) begin
                  work.push_front({cur[8] && (k == total - 1), seq[k]});
               end
            end
         end
      end
   endtask

   task automatic predict_parse(input logic [7:0] c, input logic last,
                                output ffnp_pkg::rsp_type r);
      ffnp_pkg::status_type st;
      r = '0;
      st = ffnp_pkg::STATUS_PARSED;
      if (exp_phase == ffnp_pkg::PH_FAMILY) begin
         if (char_is_alpha(c)) begin
            if (int'(exp_kept) < ffnp_pkg::NAME_CAP - 1) begin
               exp_kept = exp_kept + 6'd1;
               r.name_char = c;
               r.name_char_valid = 1'b1;
            end
            if (last) st = ffnp_pkg::STATUS_NO_SIZE;
         end else begin
            exp_phase = ffnp_pkg::PH_SIZE;
         end
      end
      if (exp_phase == ffnp_pkg::PH_SIZE) begin
         if (char_is_decimal(c)) begin
            exp_size = grow_decimal(exp_size, c);
            if (last && exp_size == 16'd0) st = ffnp_pkg::STATUS_ZERO_SIZE;
         end else if (exp_size == 16'd0) begin
            exp_phase = ffnp_pkg::PH_FAILED;
         end else begin
            exp_phase = ffnp_pkg::PH_FACE;
            feed_face(c, last);
         end
      end else if (exp_phase == ffnp_pkg::PH_FACE || exp_phase == ffnp_pkg::PH_SUFFIX) begin
         feed_face(c, last);
      end
      if (exp_phase == ffnp_pkg::PH_FAILED) st = ffnp_pkg::STATUS_ZERO_SIZE;
      if (last) begin
         r.done_res = 1'b1;
         if (st == ffnp_pkg::STATUS_PARSED) begin
            r.point_size     = exp_size;
            r.rotation       = exp_rot;
            r.bold           = exp_flags.bold;
            r.italic         = exp_flags.italic;
            r.fixed_width    = exp_flags.fixed_width;
            r.shadow         = exp_flags.shadow;
            r.bad_char_count = exp_errs;
         end else if (st == ffnp_pkg::STATUS_ZERO_SIZE) begin
            r.point_size = exp_size;
         end
         r.status = st;
         clear_parse_state();
      end
   endtask

   task automatic note_mismatch(input string msg);
      fail_count++;
      $display("ERROR: result %0d: %s", results_seen, msg);
   endtask

   task automatic check_field(input string field, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) note_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
   endtask

   task automatic add_text(input string s);
      for (int k = 0; k < s.len(); k++) name_buf.push_back(s[k]);
   endtask

   task automatic put_letter();
      int pick;
      pick = $urandom_range(0, 51);
      if (pick < 26) name_buf.push_back(CH_UPPER_A + 8'(pick));
      else name_buf.push_back(CH_LOWER_A + 8'(pick - 26));
   endtask

   task automatic put_digit();
      name_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic put_random_byte();
      name_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic flush_name();
      int n;
      n = name_buf.size();
      for (int k = 0; k < n; k++) begin
         pending_chars.push_back('{hold_off: drain_next && (k == 0),
                                   code: name_buf[k], last: (k == n - 1)});
      end
      drain_next = 1'b0;
      name_buf.delete();
   endtask

   task automatic make_random_name(input int index);
      int         kind;
      int         t;
      logic [7:0] c;
      if (index % 40 == 0) drain_next = 1'b1;
      kind = $urandom_range(0, 99);
      if (index == 3) begin
         // Enough unrecognized characters to saturate the error count.
         add_text("Err42");
         repeat (290) begin
            c = 8'($urandom_range(0, 255));
            if (c == ffnp_pkg::CH_B || c == ffnp_pkg::CH_I || c == ffnp_pkg::CH_F ||
                c == ffnp_pkg::CH_S || c == ffnp_pkg::CH_R || c == ffnp_pkg::CH_DOT)
               c = CH_AT;
            name_buf.push_back(c);
         end
      end else if (kind < 8) begin
         repeat ($urandom_range(1, 8)) put_random_byte();
      end else if (kind < 14) begin
         t = $urandom_range(0, 2);
         repeat ($urandom_range(t == 0 ? 1 : 0, 6)) put_letter();
         if (t == 1) begin
            name_buf.push_back(ffnp_pkg::CH_DOT);
            repeat ($urandom_range(0, 3)) put_random_byte();
         end else if (t == 2) begin
            repeat ($urandom_range(1, 2)) name_buf.push_back(CH_ZERO);
            repeat ($urandom_range(0, 4)) put_random_byte();
         end
      end else begin
         t = $urandom_range(0, 9);
         repeat ((t == 0) ? 0 : (t == 1) ? $urandom_range(29, 35) : $urandom_range(1, 8))
            put_letter();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(5, 7)) put_digit();
         end else begin
            name_buf.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(0, 2)) put_digit();
         end
         repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
               0: name_buf.push_back(ffnp_pkg::CH_B);
               1: name_buf.push_back(ffnp_pkg::CH_I);
               2: name_buf.push_back(ffnp_pkg::CH_F);
               3: name_buf.push_back(ffnp_pkg::CH_S);
               4: begin
                  name_buf.push_back(ffnp_pkg::CH_R);
                  repeat (($urandom_range(0, 7) == 0) ? 6 : $urandom_range(0, 3)) put_digit();
               end
               5: name_buf.push_back(ffnp_pkg::CH_DOT);
               6: put_digit();
               7: put_random_byte();
               8: begin
                  add_text(".f");
                  if ($urandom_range(0, 1) == 1) name_buf.push_back(ffnp_pkg::CH_W);
               end
               default: put_letter();
            endcase
         end
         case ($urandom_range(0, 5))
            0, 1: add_text(".fwm");
            2: add_text(".fdb");
            3: begin
               case ($urandom_range(0, 5))
                  0: add_text(".f");
                  1: add_text(".fw");
                  2: add_text(".fd");
                  3: add_text(".fwx");
                  4: add_text(".fdbq");
                  default: add_text(".fx");
               endcase
            end
            default: begin
            end
         endcase
      end
      flush_name();
   endtask

   always @(negedge clock) begin
      char_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_chars.size() == 0 ||
                   (pending_chars[0].hold_off && parse_results_due.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         nxt = pending_chars.pop_front();
         if (nxt.hold_off) drains_taken++;
         req_char_code <= nxt.code;
         req_last_char <= nxt.last;
         req_valid <= 1'b1;
         if (burst_left <= 1) begin
            if ($urandom_range(0, 3) == 0) begin
               burst_left = $urandom_range(50, 150);
               gap_left = 0;
            end else begin
               burst_left = $urandom_range(1, 20);
               gap_left = $urandom_range(1, 8);
            end
         end else begin
            burst_left--;
         end
      end
   end

   always @(negedge clock) begin
      tick++;
      if (tick % 256 == 0) ready_mode = $urandom_range(0, 3);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (tick % 8 != 5) && (tick % 8 != 6);
         endcase
      end
   end

   always @(posedge clock) begin
      ffnp_pkg::rsp_type fresh;
      ffnp_pkg::rsp_type due;
      if (reset) begin
         req_fire <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_parse(req_char_code, req_last_char, fresh);
            parse_results_due.push_back(fresh);
            chars_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (parse_results_due.size() == 0) begin
               note_mismatch("result item with no character item waiting");
            end else begin
               due = parse_results_due.pop_front();
               check_field("name_char", rsp_name_char, due.name_char);
               check_field("name_char_valid", rsp_name_char_valid, due.name_char_valid);
               check_field("done_res", rsp_done_res, due.done_res);
               check_field("point_size", rsp_point_size, due.point_size);
               check_field("rotation", rsp_rotation, due.rotation);
               check_field("bold", rsp_bold, due.bold);
               check_field("italic", rsp_italic, due.italic);
               check_field("fixed_width", rsp_fixed_width, due.fixed_width);
               check_field("shadow", rsp_shadow, due.shadow);
               check_field("bad_char_count", rsp_bad_char_count, due.bad_char_count);
               check_field("status", rsp_status, due.status);
               if (due.done_res) begin
                  names_done++;
                  status_seen[due.status]++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("font_file_name_parser test failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int random_start;
      int index;
      clear_parse_state();

      add_text("A");
      flush_name();
      add_text("0");
      flush_name();
      add_text("q.x");
      flush_name();
      name_buf.push_back(8'hFF);
      flush_name();
      add_text("7bisfr12r.fwm");
      flush_name();
      add_text("5.fd");
      flush_name();
      add_text("Z9");
      name_buf.push_back(8'h00);
      flush_name();

      random_start = pending_chars.size();
      index = 0;
      while (pending_chars.size() - random_start < RANDOM_CHARS) begin
         make_random_name(index);
         index++;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_chars.size() > 0 || req_valid || parse_results_due.size() > 0)
         @(negedge clock);
      repeat (10) @(posedge clock);

      if (parse_results_due.size() != 0)
         note_mismatch($sformatf("%0d result items never arrived", parse_results_due.size()));

      $display("Covered %0d names in %0d character items, %0d result items, %0d drain pauses.",
               names_done, chars_taken, results_seen, drains_taken);
      $display("Names parsed %0d, ended in family %0d, zero or missing size %0d.",
               status_seen[0], status_seen[1], status_seen[2]);
      if (fail_count == 0) begin
         $display("font_file_name_parser test passed");
      end else begin
         $display("font_file_name_parser test failed");
      end
      $finish;
   end

endmodule

[font_file_name_parser.f]
src/ffnp_pkg.sv
src/ffnp_in_stage.sv
src/ffnp_parser.sv
src/ffnp_out_stage.sv
src/font_file_name_parser.sv
tb/tb.sv
